// ===== rtl/core/tscpq_pkg.sv =====
// shared constants, codes and types for the three-class priority queue
`default_nettype none
package tscpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_CLASSES = 3;

	localparam int TAG_W   = 32;
	localparam int CLS_W   = 2;
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W  = $clog2(NUM_CLASSES * QUEUE_DEPTH);
	localparam int STORE_D = NUM_CLASSES * QUEUE_DEPTH;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [CLS_W-1:0] CLASS_NONE = 2'd0;

	typedef enum logic [2:0] {
		ST_ENQUEUED  = 3'd0,
		ST_DROPPED   = 3'd1,
		ST_BAD_CLASS = 3'd2,
		ST_DEQUEUED  = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/core/tscpq_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module tscpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/three_class_strict_priority_queue.sv =====
// Three FIFO queues of 32-bit tags served in strict priority, class 1 first.
// Each queue holds QUEUE_DEPTH tags in its own region of one tag ram; read and
// write pointers and fill counts sit in flops. An enqueue, a rejected enqueue
// (bad class or full queue) and a dequeue that finds all queues empty are
// answered in the cycle after accept. A tag dequeue passes the registered read
// of the tag ram, then the result register; no new beat is taken while that
// read is in flight. Else a new beat is taken whenever the result register is
// empty or being drained in the same cycle. The tag ram needs no clearing
// after reset: an entry is read only after it was written.
`default_nettype none
module three_class_strict_priority_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	output logic                            cmd_ready,
	input  wire logic                       cmd,
	input  wire logic [tscpq_pkg::CLS_W-1:0] class_code,
	input  wire logic [tscpq_pkg::TAG_W-1:0] item_id,
	output logic                            result_valid,
	input  wire logic                       result_ready,
	output tscpq_pkg::status_t              status,
	output logic      [tscpq_pkg::TAG_W-1:0] out_id,
	output logic      [tscpq_pkg::CLS_W-1:0] out_class
);

	import tscpq_pkg::*;

	logic [PTR_W-1:0] rd_ptr_q [NUM_CLASSES];
	logic [PTR_W-1:0] wr_ptr_q [NUM_CLASSES];
	logic [CNT_W-1:0] cnt_q    [NUM_CLASSES];

	logic             deq_s1;
	logic [CLS_W-1:0] class_s1;

	logic             result_valid_q;
	status_t          status_q;
	logic [TAG_W-1:0] out_id_q;
	logic [CLS_W-1:0] out_class_q;

	logic [NUM_CLASSES-1:0] nonempty;
	logic             accept;
	logic             is_deq;
	logic             class_ok;
	logic             any_waiting;
	logic [CLS_W-1:0] deq_idx;
	logic [CLS_W-1:0] enq_idx;
	logic [CLS_W-1:0] sel;
	logic             full;
	logic             do_enq;
	logic             do_deq;
	logic [PTR_W-1:0] sel_wr_ptr;
	logic [PTR_W-1:0] sel_rd_ptr;
	logic [PTR_W-1:0] ptr_used;
	logic [PTR_W-1:0] ptr_next;
	logic [ADDR_W-1:0] ram_addr;
	logic [TAG_W-1:0] rd_data;
	status_t          imm_status;

	always_comb begin
		for (int i = 0; i < NUM_CLASSES; i++) begin
			nonempty[i] = (cnt_q[i] != '0);
		end
	end

	assign accept      = cmd_valid && cmd_ready;
	assign cmd_ready   = !deq_s1 && (!result_valid_q || result_ready);
	assign is_deq      = (cmd == CMD_DEQ);
	assign class_ok    = (class_code != CLASS_NONE);
	assign any_waiting = |nonempty;

	// strict priority: lowest index with a waiting tag
	assign deq_idx = nonempty[0] ? 2'd0 : (nonempty[1] ? 2'd1 : 2'd2);
	assign enq_idx = class_ok ? (class_code - 2'd1) : 2'd0;
	assign sel     = is_deq ? deq_idx : enq_idx;

	assign sel_wr_ptr = wr_ptr_q[sel];
	assign sel_rd_ptr = rd_ptr_q[sel];
	assign full       = (cnt_q[sel] == CNT_W'(QUEUE_DEPTH));

	assign do_enq = accept && !is_deq && class_ok && !full;
	assign do_deq = accept && is_deq && any_waiting;

	assign ptr_used = is_deq ? sel_rd_ptr : sel_wr_ptr;
	assign ptr_next = (ptr_used == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_used + 1'b1;
	assign ram_addr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr_used);

	always_comb begin
		if (is_deq) begin
			imm_status = ST_EMPTY;
		end else if (!class_ok) begin
			imm_status = ST_BAD_CLASS;
		end else if (full) begin
			imm_status = ST_DROPPED;
		end else begin
			imm_status = ST_ENQUEUED;
		end
	end

	tscpq_ram #(
		.WIDTH(TAG_W),
		.DEPTH(STORE_D)
	) u_tag_ram (
		.clk    (clk),
		.wr_en  (do_enq),
		.wr_addr(ram_addr),
		.wr_data(item_id),
		.rd_en  (do_deq),
		.rd_addr(ram_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				cnt_q[i]    <= '0;
			end
		end else if (do_enq) begin
			wr_ptr_q[sel] <= ptr_next;
			cnt_q[sel]    <= cnt_q[sel] + 1'b1;
		end else if (do_deq) begin
			rd_ptr_q[sel] <= ptr_next;
			cnt_q[sel]    <= cnt_q[sel] - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deq_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			deq_s1 <= do_deq;
			if ((accept && !do_deq) || deq_s1) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_deq) begin
			class_s1 <= sel + 2'd1;
		end
		if (deq_s1) begin
			// tag arrives from the ram in the cycle after the read
			status_q    <= ST_DEQUEUED;
			out_id_q    <= rd_data;
			out_class_q <= class_s1;
		end else if (accept && !do_deq) begin
			status_q    <= imm_status;
			out_id_q    <= '0;
			out_class_q <= CLASS_NONE;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign out_id       = out_id_q;
	assign out_class    = out_class_q;

endmodule
`default_nettype wire

// ===== rtl/core/tscpq_checker.sv =====
// port-level checks for the three-class priority queue and their binding
`default_nettype none
module tscpq_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       cmd_valid,
	input wire logic                       cmd_ready,
	input wire logic                       cmd,
	input wire logic                       result_valid,
	input wire logic                       result_ready,
	input wire logic [2:0]                 status,
	input wire logic [tscpq_pkg::TAG_W-1:0] out_id,
	input wire logic [tscpq_pkg::CLS_W-1:0] out_class
);

	import tscpq_pkg::*;

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(status) && $stable(out_id) && $stable(out_class))
		else $error("result beat changed while stalled");

	// any enqueue beat is answered on the next cycle
	a_enq_answer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd == CMD_ENQ |=> result_valid)
		else $error("enqueue not answered in one cycle");

	// only a dequeued beat carries a tag and a class
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_DEQUEUED |-> out_id == '0 && out_class == CLASS_NONE)
		else $error("non-dequeue result carries tag or class");

	a_deq_class: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_DEQUEUED |-> out_class != CLASS_NONE)
		else $error("dequeued tag without a class");

endmodule

bind three_class_strict_priority_queue tscpq_checker u_tscpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_ready   (cmd_ready),
	.cmd         (cmd),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.status      (status),
	.out_id      (out_id),
	.out_class   (out_class)
);
`default_nettype wire

// ===== tb/sv/tb_three_class_strict_priority_queue.sv =====
// testbench for the three-class strict-priority tag queue: directed table, then random beats
`timescale 1ns / 1ps
module tb_three_class_strict_priority_queue;
	import tscpq_pkg::*;

	localparam logic [CLS_W-1:0] CLASS_HI  = 2'd1;
	localparam logic [CLS_W-1:0] CLASS_MID = 2'd2;
	localparam logic [CLS_W-1:0] CLASS_LO  = 2'd3;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int CHUNK_ITEMS  = 50;
	localparam int NUM_CHUNKS   = 25;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		status_t          status;
		logic [TAG_W-1:0] id;
		logic [CLS_W-1:0] cls;
	} outcome_t;

	typedef struct {
		logic             op;
		logic [CLS_W-1:0] cc;
		logic [TAG_W-1:0] id;
		int               reps;
		bit               typed;
		status_t          status;
	} plan_row_t;

	localparam int PLAN_ROWS = 12;

	// typed rows carry only a status: id and class are zero for those outcomes
	plan_row_t directed_plan [PLAN_ROWS] = '{
		'{CMD_DEQ, CLASS_NONE, 32'h0000_0000, 1, 1'b1, ST_EMPTY},
		'{CMD_ENQ, CLASS_NONE, 32'hFFFF_FFFF, 1, 1'b1, ST_BAD_CLASS},
		'{CMD_ENQ, CLASS_LO,   32'h0000_0000, 1, 1'b1, ST_ENQUEUED},
		'{CMD_ENQ, CLASS_MID,  32'hFFFF_FFFF, 1, 1'b1, ST_ENQUEUED},
		'{CMD_ENQ, CLASS_HI,   32'h1234_5678, 1, 1'b1, ST_ENQUEUED},
		'{CMD_DEQ, CLASS_LO,   32'hA5A5_A5A5, 1, 1'b0, ST_DEQUEUED},
		'{CMD_DEQ, CLASS_NONE, 32'hFFFF_FFFF, 1, 1'b0, ST_DEQUEUED},
		'{CMD_DEQ, CLASS_MID,  32'h0000_0000, 1, 1'b0, ST_DEQUEUED},
		'{CMD_DEQ, CLASS_HI,   32'h5A5A_5A5A, 1, 1'b1, ST_EMPTY},
		'{CMD_ENQ, CLASS_LO,   32'h8000_0000, QUEUE_DEPTH, 1'b1, ST_ENQUEUED},
		'{CMD_ENQ, CLASS_LO,   32'h0000_0000, 1, 1'b1, ST_DROPPED},
		'{CMD_DEQ, CLASS_NONE, 32'h0000_0000, 1, 1'b0, ST_DEQUEUED}
	};

	logic             clk;
	logic             arst_n;
	logic             cmd_valid;
	logic             cmd_ready;
	logic             cmd;
	logic [CLS_W-1:0] class_code;
	logic [TAG_W-1:0] item_id;
	logic             result_valid;
	logic             result_ready;
	status_t          status;
	logic [TAG_W-1:0] out_id;
	logic [CLS_W-1:0] out_class;

	// held with the beat so the monitor knows whether the table typed the answer
	logic             typed_on;
	status_t          typed_status;

	three_class_strict_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.class_code   (class_code),
		.item_id      (item_id),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.out_id       (out_id),
		.out_class    (out_class)
	);

	// shadow queue state
	logic [TAG_W-1:0] shadow_tags [NUM_CLASSES][QUEUE_DEPTH];
	int unsigned      shadow_rd   [NUM_CLASSES];
	int unsigned      shadow_wr   [NUM_CLASSES];
	int unsigned      shadow_fill [NUM_CLASSES];

	outcome_t pending_outcomes [$];
	int       fail_count;
	int       stall_cycles;
	bit       steady;
	int       hold_ask;
	int       hold_seen;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned wrap_inc(int unsigned p);
		return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
	endfunction

	function automatic outcome_t queue_step(logic op, logic [CLS_W-1:0] cc,
			logic [TAG_W-1:0] id);
		outcome_t r;
		int       q;
		bit       found;
		r = '{ST_EMPTY, '0, CLASS_NONE};
		found = 1'b0;
		if (op == CMD_ENQ) begin
			if (cc == CLASS_NONE) begin
				r.status = ST_BAD_CLASS;
			end else begin
				q = int'(cc) - 1;
				if (shadow_fill[q] >= QUEUE_DEPTH) begin
					r.status = ST_DROPPED;
				end else begin
					shadow_tags[q][shadow_wr[q]] = id;
					shadow_wr[q] = wrap_inc(shadow_wr[q]);
					shadow_fill[q]++;
					r.status = ST_ENQUEUED;
				end
			end
		end else begin
			// strict priority: lowest class index wins
			for (q = 0; q < NUM_CLASSES; q++) begin
				if (!found && shadow_fill[q] != 0) begin
					found = 1'b1;
					r.status = ST_DEQUEUED;
					r.id = shadow_tags[q][shadow_rd[q]];
					r.cls = CLS_W'(q + 1);
					shadow_rd[q] = wrap_inc(shadow_rd[q]);
					shadow_fill[q]--;
				end
			end
		end
		return r;
	endfunction

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%t mismatch: %s", $realtime, msg);
	endfunction

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return $urandom_range(1, 2);
		else if (pick < 95)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// beat monitor: predicts on every accepted command, checks every accepted result
	always @(posedge clk) begin
		outcome_t model;
		outcome_t want;
		outcome_t got;
		if ((cmd_valid && cmd_ready) || (result_valid && result_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				model = queue_step(cmd, class_code, item_id);
				if (typed_on)
					want = '{typed_status, '0, CLASS_NONE};
				else
					want = model;
				pending_outcomes.push_back(want);
			end
			if (result_valid && result_ready) begin
				got = '{status, out_id, out_class};
				if (pending_outcomes.size() == 0) begin
					note_failure($sformatf("result with nothing pending: status=%0d id=%h class=%0d",
						got.status, got.id, got.cls));
				end else begin
					want = pending_outcomes.pop_front();
					if (got.status !== want.status || got.id !== want.id
							|| got.cls !== want.cls)
						note_failure($sformatf(
							"status exp %0d got %0d, id exp %h got %h, class exp %0d got %0d",
							want.status, got.status, want.id, got.id, want.cls, got.cls));
				end
			end
		end
	end

	// receiver: random ready pattern, plus long hold-offs on request
	initial begin
		int n;
		result_ready <= 1'b0;
		hold_seen = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				result_ready <= 1'b0;
				n = HOLD_CYCLES;
			end else if (steady || $urandom_range(2) != 0) begin
				result_ready <= 1'b1;
				n = steady ? 1 : $urandom_range(1, 8);
			end else begin
				result_ready <= 1'b0;
				n = gap_len();
			end
			repeat (n)
				@(posedge clk);
		end
	end

	task automatic offer_beat(input logic op, input logic [CLS_W-1:0] cc,
			input logic [TAG_W-1:0] id, input bit typed, input status_t st);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(2) == 0)
			gap = gap_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
		cmd_valid    <= 1'b1;
		cmd          <= op;
		class_code   <= cc;
		item_id      <= id;
		typed_on     <= typed;
		typed_status <= st;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int               enq_pct;
		logic             op;
		logic [CLS_W-1:0] cc;
		logic [TAG_W-1:0] id;
		arst_n       <= 1'b0;
		cmd_valid    <= 1'b0;
		cmd          <= CMD_ENQ;
		class_code   <= CLASS_NONE;
		item_id      <= '0;
		typed_on     <= 1'b0;
		typed_status <= ST_ENQUEUED;
		fail_count   = 0;
		stall_cycles = 0;
		steady       = 1'b0;
		hold_ask     = 0;
		for (int q = 0; q < NUM_CLASSES; q++) begin
			shadow_rd[q]   = 0;
			shadow_wr[q]   = 0;
			shadow_fill[q] = 0;
		end
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[r])
			for (int k = 0; k < directed_plan[r].reps; k++)
				offer_beat(directed_plan[r].op, directed_plan[r].cc,
					directed_plan[r].id + TAG_W'(k), directed_plan[r].typed,
					directed_plan[r].status);

		for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
			case ($urandom_range(4))
				0: enq_pct = 15;
				1, 2: enq_pct = 50;
				3: enq_pct = 85;
				default: enq_pct = 97;
			endcase
			steady = ($urandom_range(3) == 0);
			// back up the output so the result register stays full and stalls the input
			if (chunk == 5 || chunk == 17) begin
				enq_pct = 85;
				steady = 1'b1;
				hold_ask++;
			end
			for (int i = 0; i < CHUNK_ITEMS; i++) begin
				op = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
				if ($urandom_range(19) == 0)
					cc = CLASS_NONE;
				else
					cc = CLS_W'($urandom_range(1, 3));
				case ($urandom_range(7))
					0: id = '0;
					1: id = '1;
					default: id = $urandom;
				endcase
				offer_beat(op, cc, id, 1'b0, ST_ENQUEUED);
			end
		end
		cmd_valid <= 1'b0;
		steady = 1'b0;
		// let the monitor log the last accepted beat before waiting on it
		@(posedge clk);

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tscpq_pkg.sv
rtl/core/tscpq_ram.sv
rtl/core/three_class_strict_priority_queue.sv
rtl/core/tscpq_checker.sv
tb/sv/tb_three_class_strict_priority_queue.sv
